// File: rtl/rrss_pkg.sv
// Shared types and codes for the round-robin slice scheduler.
`timescale 1ns / 1ps

package rrss_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_FIND = 7'b0000100,
    S_RDID = 7'b0001000,
    S_RDRT = 7'b0010000,
    S_CALC = 7'b0100000,
    S_DEL  = 7'b1000000
  } state_t;

  // Operation codes on the func input.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_SLICE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOWORK   = 2'd3;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  // One result beat as it is loaded into the output registers.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  job;
    logic [19:0] t_start;
    logic [19:0] t_end;
    logic        job_fin;
    logic        all_fin;
  } result_t;

endpackage

// File: rtl/round_robin_slice_scheduler.sv
// Round-robin slice scheduler with a configurable quantum: ring memory and sequencer.
`timescale 1ns / 1ps

// Channel     Direction  Signals                                        Handshake
// ----------  ---------  ---------------------------------------------  --------------------------
// command     in         func, priority_req, burst_time, job_id         start high while busy low
// result      out        status, slice_job, slice_start, slice_end,     done high for one cycle
//                        job_finished, all_finished
// quantum     in         cfg_data                                       cfg_we high
//
// A load walks the ring down from its top, one entry a cycle, moving up each entry of higher
// priority. A start searches the ring upwards. A slice reads the ring, then the remaining
// time, then updates; a finished job then closes up the ring behind it.
// Rejected items and slices with no work never raise busy. Every result beat shows for one
// cycle once the sequencer is idle, as the receiver cannot stall; reset clears control only.
module round_robin_slice_scheduler #(
  parameter int MAX_JOBS  = 16,
  parameter int TIME_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  priority_req,
  input  logic [15:0] burst_time,
  input  logic [3:0]  job_id,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slice_job,
  output logic [19:0] slice_start,
  output logic [19:0] slice_end,
  output logic        job_finished,
  output logic        all_finished
);

  localparam int AW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  // A ring entry holds the job id above its priority.
  localparam int EW = AW + 8;

  rrss_pkg::state_t state;

  logic [7:0]           quantum;
  logic [CW-1:0]        loaded;
  logic [CW-1:0]        live;
  logic [AW-1:0]        rp;
  logic [TIME_BITS-1:0] clock_time;
  logic                 running;

  // Per-item working registers.
  logic [7:0]    new_prio;
  logic [AW-1:0] new_id;
  logic [3:0]    job_req;
  logic [AW-1:0] pos;
  logic [CW-1:0] walk;
  logic [AW-1:0] chk;
  logic          pend;
  logic [AW-1:0] cur_id;
  logic [19:0]   hold_t0;

  // Ring memory: entries 0 .. live-1 in ascending priority order.
  logic [EW-1:0] ring_mem [MAX_JOBS];
  logic [EW-1:0] ring_rd;
  logic          ring_we;
  logic [AW-1:0] ring_wa;
  logic [EW-1:0] ring_wd;
  logic [AW-1:0] ring_ra;

  // Remaining work per job id.
  logic [15:0]   rt_mem [MAX_JOBS];
  logic [15:0]   rt_rd;
  logic          rt_we;
  logic [AW-1:0] rt_wa;
  logic [15:0]   rt_wd;
  logic [AW-1:0] rt_ra;

  logic [7:0]    rd_prio;
  logic [AW-1:0] rd_id;
  logic [EW-1:0] new_entry;

  logic load_reject;
  logic load_cont;
  logic load_end;
  logic find_hit;
  logic find_end;
  logic del_end;

  // Shared slice arithmetic: one compare, one subtract and one add.
  logic [15:0]          q16;
  logic [15:0]          run16;
  logic [15:0]          rem;
  logic [TIME_BITS-1:0] clock_next;
  logic                 slice_fin;

  logic              emit;
  rrss_pkg::result_t res;

  assign busy = (state != rrss_pkg::S_IDLE);

  assign rd_prio   = ring_rd[7:0];
  assign rd_id     = ring_rd[EW-1:8];
  assign new_entry = {new_id, new_prio};

  assign load_reject = running || (burst_time == 16'd0) ||
                       (loaded >= CW'(MAX_JOBS)) || (live >= CW'(MAX_JOBS));

  // While walking down for a load, an entry of strictly higher priority moves up one place;
  // the first entry of equal or lower priority marks where the new job goes.
  assign load_cont = pend && (rd_prio > new_prio);
  assign load_end  = (pend && !load_cont) || (!pend && (walk == '0));

  assign find_hit = pend && (8'(rd_id) == 8'(job_req));
  assign find_end = find_hit || (walk >= live);

  assign del_end = !pend && (walk >= live);

  assign q16        = {8'd0, quantum};
  assign run16      = (rt_rd > q16) ? q16 : rt_rd;
  assign rem        = rt_rd - run16;
  assign clock_next = clock_time + TIME_BITS'(run16);
  assign slice_fin  = (rem == 16'd0);

  assign rt_ra = rd_id;

  // Ring memory port control.
  always_comb begin
    ring_we = 1'b0;
    ring_wa = '0;
    ring_wd = ring_rd;
    ring_ra = '0;
    case (state)
      rrss_pkg::S_LOAD: begin
        ring_we = pend || (walk == '0);
        ring_wa = pend ? (chk + AW'(1)) : '0;
        ring_wd = load_cont ? ring_rd : new_entry;
        ring_ra = AW'(walk - CW'(1));
      end
      rrss_pkg::S_FIND: begin
        ring_ra = walk[AW-1:0];
      end
      rrss_pkg::S_RDID: begin
        ring_ra = pos;
      end
      rrss_pkg::S_DEL: begin
        ring_we = pend;
        ring_wa = chk - AW'(1);
        ring_ra = walk[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Remaining-time memory port control.
  always_comb begin
    rt_we = 1'b0;
    rt_wa = cur_id;
    rt_wd = rem;
    if (state == rrss_pkg::S_IDLE) begin
      rt_we = start && (func == rrss_pkg::FUNC_LOAD) && !load_reject;
      rt_wa = loaded[AW-1:0];
      rt_wd = burst_time;
    end else if (state == rrss_pkg::S_CALC) begin
      rt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_wa] <= rt_wd;
    end
    rt_rd <= rt_mem[rt_ra];
  end

  // Result beat selection.
  always_comb begin
    emit = 1'b0;
    res  = '{status: rrss_pkg::ST_OK, job: 4'd0, t_start: 20'd0, t_end: 20'd0,
             job_fin: 1'b0, all_fin: 1'b0};
    case (state)
      rrss_pkg::S_IDLE: begin
        if (start) begin
          case (func)
            rrss_pkg::FUNC_LOAD: begin
              if (load_reject) begin
                emit       = 1'b1;
                res.status = rrss_pkg::ST_REJECT;
              end
            end
            rrss_pkg::FUNC_START: begin
              if (running) begin
                emit       = 1'b1;
                res.status = rrss_pkg::ST_NOTFOUND;
              end
            end
            rrss_pkg::FUNC_SLICE: begin
              if (!running) begin
                emit       = 1'b1;
                res.status = rrss_pkg::ST_NOTFOUND;
              end else if (live == '0) begin
                emit        = 1'b1;
                res.status  = rrss_pkg::ST_NOWORK;
                res.t_start = 20'(clock_time);
                res.t_end   = 20'(clock_time);
                res.all_fin = 1'b1;
              end
            end
            default: begin
              emit       = 1'b1;
              res.status = rrss_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      rrss_pkg::S_LOAD: begin
        if (load_end) begin
          emit    = 1'b1;
          res.job = 4'(new_id);
        end
      end
      rrss_pkg::S_FIND: begin
        if (find_end) begin
          emit = 1'b1;
          if (find_hit) begin
            res.job = job_req;
          end else begin
            res.status = rrss_pkg::ST_NOTFOUND;
          end
        end
      end
      rrss_pkg::S_CALC: begin
        if (!slice_fin) begin
          emit        = 1'b1;
          res.job     = 4'(cur_id);
          res.t_start = 20'(clock_time);
          res.t_end   = 20'(clock_next);
        end
      end
      rrss_pkg::S_DEL: begin
        if (del_end) begin
          emit        = 1'b1;
          res.job     = 4'(cur_id);
          res.t_start = hold_t0;
          res.t_end   = 20'(clock_time);
          res.job_fin = 1'b1;
          res.all_fin = (live == CW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Output registers: the strobe is reset, the payload only loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
    if (emit) begin
      status       <= res.status;
      slice_job    <= res.job;
      slice_start  <= res.t_start;
      slice_end    <= res.t_end;
      job_finished <= res.job_fin;
      all_finished <= res.all_fin;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rrss_pkg::S_IDLE;
      quantum    <= rrss_pkg::QUANTUM_RESET;
      loaded     <= '0;
      live       <= '0;
      rp         <= '0;
      clock_time <= '0;
      running    <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_data;
      end
      case (state)
        rrss_pkg::S_IDLE: begin
          if (start) begin
            case (func)
              rrss_pkg::FUNC_LOAD: begin
                if (!load_reject) begin
                  new_prio <= priority_req;
                  new_id   <= loaded[AW-1:0];
                  walk     <= live;
                  pend     <= 1'b0;
                  state    <= rrss_pkg::S_LOAD;
                end
              end
              rrss_pkg::FUNC_START: begin
                if (!running) begin
                  job_req <= job_id;
                  walk    <= '0;
                  pend    <= 1'b0;
                  state   <= rrss_pkg::S_FIND;
                end
              end
              rrss_pkg::FUNC_SLICE: begin
                if (running && (live != '0)) begin
                  pos   <= (CW'(rp) >= live) ? '0 : rp;
                  state <= rrss_pkg::S_RDID;
                end
              end
              default: begin
              end
            endcase
          end
        end
        rrss_pkg::S_LOAD: begin
          if (load_end) begin
            live   <= live + CW'(1);
            loaded <= loaded + CW'(1);
            state  <= rrss_pkg::S_IDLE;
          end else if (walk != '0) begin
            chk  <= ring_ra;
            walk <= walk - CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        rrss_pkg::S_FIND: begin
          if (find_end) begin
            if (find_hit) begin
              running    <= 1'b1;
              rp         <= chk;
              clock_time <= '0;
            end
            state <= rrss_pkg::S_IDLE;
          end else begin
            chk  <= ring_ra;
            walk <= walk + CW'(1);
            pend <= 1'b1;
          end
        end
        rrss_pkg::S_RDID: begin
          state <= rrss_pkg::S_RDRT;
        end
        rrss_pkg::S_RDRT: begin
          cur_id <= rd_id;
          state  <= rrss_pkg::S_CALC;
        end
        rrss_pkg::S_CALC: begin
          clock_time <= clock_next;
          hold_t0    <= 20'(clock_time);
          if (slice_fin) begin
            walk  <= CW'(pos) + CW'(1);
            pend  <= 1'b0;
            state <= rrss_pkg::S_DEL;
          end else begin
            rp    <= ((CW'(pos) + CW'(1)) >= live) ? '0 : (pos + AW'(1));
            state <= rrss_pkg::S_IDLE;
          end
        end
        rrss_pkg::S_DEL: begin
          if (del_end) begin
            live  <= live - CW'(1);
            rp    <= (CW'(pos) >= (live - CW'(1))) ? '0 : pos;
            state <= rrss_pkg::S_IDLE;
          end else if (walk < live) begin
            chk  <= ring_ra;
            walk <= walk + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        default: begin
          state <= rrss_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A result beat only ever appears once the sequencer is back at idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // The ring never holds more jobs than have been loaded, nor more than it can hold.
  assert property (@(posedge clk) disable iff (rst)
    (live <= loaded) && (live <= CW'(MAX_JOBS)))
    else $error("ring count out of range");

  // Once scheduling has begun it is never left.
  assert property (@(posedge clk) disable iff (rst) running |=> running)
    else $error("running dropped");

  // Ring writes never land beyond the slot just above the live entries.
  assert property (@(posedge clk) disable iff (rst) ring_we |-> (CW'(ring_wa) <= live))
    else $error("ring write beyond live entries");
`endif

endmodule

// File: tb/slice_checker.sv
// Checker for the round-robin slice scheduler: predicts every result beat and compares it.
`timescale 1ns / 1ps

module slice_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  priority_req,
  input  logic [15:0] burst_time,
  input  logic [3:0]  job_id,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [3:0]  slice_job,
  input  logic [19:0] slice_start,
  input  logic [19:0] slice_end,
  input  logic        job_finished,
  input  logic        all_finished,
  output int          mismatches,
  output int          pending
);

  localparam int unsigned JOBS = 16;

  // Scheduler state as the checker sees it.
  logic [3:0]  ring_id  [JOBS];
  logic [7:0]  ring_pri [JOBS];
  logic [15:0] work_left [JOBS];
  int unsigned n_loaded;
  int unsigned n_live;
  int unsigned ring_pos;
  logic [19:0] sched_clock;
  logic        sched_running;
  logic [7:0]  slice_quantum;

  rrss_pkg::result_t expected_beats[$];
  int      fail_tally = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Applies one command to the predicted state and returns the beat it should produce.
  function automatic rrss_pkg::result_t schedule_step(input logic [1:0] f,
                                                      input logic [7:0] pri,
                                                      input logic [15:0] burst,
                                                      input logic [3:0] jid);
    rrss_pkg::result_t r;
    int unsigned slot;
    int unsigned k;
    logic [3:0]  id;
    logic [15:0] run_len;
    logic        finished;
    r = '0;
    case (f)
      rrss_pkg::FUNC_LOAD: begin
        if (sched_running || burst == 16'd0 || n_loaded >= JOBS || n_live >= JOBS) begin
          r.status = rrss_pkg::ST_REJECT;
        end else begin
          // A new job goes behind every job of equal or lower priority value.
          slot = 0;
          while (slot < n_live && ring_pri[slot] <= pri) slot++;
          for (k = n_live; k > slot; k--) begin
            ring_id[k]  = ring_id[k - 1];
            ring_pri[k] = ring_pri[k - 1];
          end
          ring_id[slot]       = 4'(n_loaded);
          ring_pri[slot]      = pri;
          work_left[n_loaded] = burst;
          r.status = rrss_pkg::ST_OK;
          r.job    = 4'(n_loaded);
          n_live++;
          n_loaded++;
        end
      end
      rrss_pkg::FUNC_START: begin
        r.status = rrss_pkg::ST_NOTFOUND;
        if (!sched_running) begin
          for (k = 0; k < n_live; k++) begin
            if (ring_id[k] == jid && r.status != rrss_pkg::ST_OK) begin
              ring_pos    = k;
              sched_clock = '0;
              r.status    = rrss_pkg::ST_OK;
              r.job       = jid;
            end
          end
          if (r.status == rrss_pkg::ST_OK) sched_running = 1'b1;
        end
      end
      rrss_pkg::FUNC_SLICE: begin
        if (!sched_running) begin
          r.status = rrss_pkg::ST_NOTFOUND;
        end else if (n_live == 0) begin
          r.status  = rrss_pkg::ST_NOWORK;
          r.t_start = sched_clock;
          r.t_end   = sched_clock;
          r.all_fin = 1'b1;
        end else begin
          slot    = (ring_pos >= n_live) ? 0 : ring_pos;
          id      = ring_id[slot];
          run_len = (work_left[id] > 16'(slice_quantum)) ? 16'(slice_quantum) : work_left[id];
          r.t_start     = sched_clock;
          sched_clock   = sched_clock + 20'(run_len);
          work_left[id] = work_left[id] - run_len;
          finished      = (work_left[id] == 16'd0);
          if (finished) begin
            // The ring closes up behind the finished job; its successor runs next.
            for (k = slot; k + 1 < n_live; k++) begin
              ring_id[k]  = ring_id[k + 1];
              ring_pri[k] = ring_pri[k + 1];
            end
            n_live--;
            ring_pos = (slot >= n_live) ? 0 : slot;
          end else begin
            ring_pos = (slot + 1 >= n_live) ? 0 : slot + 1;
          end
          r.status  = rrss_pkg::ST_OK;
          r.job     = id;
          r.t_end   = sched_clock;
          r.job_fin = finished;
          r.all_fin = (n_live == 0);
        end
      end
      default: r.status = rrss_pkg::ST_NOTFOUND;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [19:0] want, input logic [19:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    rrss_pkg::result_t want;
    if (rst) begin
      n_loaded      = 0;
      n_live        = 0;
      ring_pos      = 0;
      sched_clock   = '0;
      sched_running = 1'b0;
      slice_quantum = rrss_pkg::QUANTUM_RESET;
      expected_beats.delete();
    end else begin
      // The beat on the result ports belongs to the oldest command still waiting.
      if (done) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no command waiting for it");
          fail_tally++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", 20'(want.status), 20'(status));
          check_field("slice_job", 20'(want.job), 20'(slice_job));
          check_field("slice_start", want.t_start, slice_start);
          check_field("slice_end", want.t_end, slice_end);
          check_field("job_finished", 20'(want.job_fin), 20'(job_finished));
          check_field("all_finished", 20'(want.all_fin), 20'(all_finished));
        end
      end
      if (cfg_we) slice_quantum = cfg_data;
      if (start && !busy)
        expected_beats.push_back(schedule_step(func, priority_req, burst_time, job_id));
    end
    mismatches <= fail_tally;
    pending    <= expected_beats.size();
  end

endmodule

// File: tb/tb_round_robin_slice_scheduler.sv
// Testbench top for the round-robin slice scheduler: command stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_round_robin_slice_scheduler;

  // The block gives this code no name; it must be answered as an unknown command.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles without any accepted beat before the run is declared hung. The slowest
  // command is a finishing slice on a full ring, and random gaps are short, so this
  // leaves a very wide margin.
  localparam int STALL_LIMIT = 2000;
  // Settling time after the last expected beat, a little above the slowest command.
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [7:0]  priority_req;
  logic [15:0] burst_time;
  logic [3:0]  job_id;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  slice_job;
  logic [19:0] slice_start;
  logic [19:0] slice_end;
  logic        job_finished;
  logic        all_finished;

  int   mismatches;
  int   pending;
  int   stall_cycles = 0;
  logic work_over = 1'b0;
  // When set, the command side sends back to back with no idle cycles at all.
  bit   steady = 1'b0;

  round_robin_slice_scheduler u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .priority_req (priority_req),
    .burst_time   (burst_time),
    .job_id       (job_id),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slice_job    (slice_job),
    .slice_start  (slice_start),
    .slice_end    (slice_end),
    .job_finished (job_finished),
    .all_finished (all_finished)
  );

  slice_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .priority_req (priority_req),
    .burst_time   (burst_time),
    .job_id       (job_id),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slice_job    (slice_job),
    .slice_start  (slice_start),
    .slice_end    (slice_end),
    .job_finished (job_finished),
    .all_finished (all_finished),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog counts cycles in which neither a command nor a result beat moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The last slice of the last job, or any slice once the ring is empty, reports that
  // all work is over; the final phase keeps slicing until it has seen this.
  always @(posedge clk) begin
    if (rst) begin
      work_over <= 1'b0;
    end else if (done && all_finished) begin
      work_over <= 1'b1;
    end
  end

  // Sends one command beat and returns at the clock edge that accepts it. An idle gap
  // may come first; start is lowered only when a gap is really taken, so it is never
  // lowered and raised again within one time step.
  task automatic issue(input logic [1:0] f, input logic [7:0] pri, input logic [15:0] burst,
                       input logic [3:0] jid);
    if (!steady && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 17) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= f;
    priority_req <= pri;
    burst_time   <= burst;
    job_id       <= jid;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Changes the quantum only once every expected beat is back and the block is idle.
  task automatic write_quantum(input logic [7:0] q);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= q;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly slice commands, with a sprinkling of commands that the running scheduler
  // must turn away: late loads, second starts and the unused code. The fields that a
  // slice ignores carry random values throughout.
  task automatic run_slices(input int count);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        issue(rrss_pkg::FUNC_LOAD, 8'($urandom), 16'($urandom_range(1, 65535)),
              4'($urandom));
      end else if (pick < 6) begin
        issue(rrss_pkg::FUNC_START, 8'($urandom), 16'($urandom), 4'($urandom));
      end else if (pick < 8) begin
        issue(FUNC_UNUSED, 8'($urandom), 16'($urandom), 4'($urandom));
      end else begin
        issue(rrss_pkg::FUNC_SLICE, 8'($urandom), 16'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    int          jobs;
    int          pick;
    int          count;
    logic [7:0]  pri;
    logic [15:0] burst;

    rst          = 1'b1;
    start        = 1'b0;
    func         = rrss_pkg::FUNC_LOAD;
    priority_req = '0;
    burst_time   = '0;
    job_id       = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening. Before any start, slices and the unused code are refused, and
    // a start on an empty ring finds nothing.
    issue(rrss_pkg::FUNC_SLICE, 8'h00, 16'h0000, 4'h0);
    issue(FUNC_UNUSED, 8'hFF, 16'hFFFF, 4'hF);
    issue(rrss_pkg::FUNC_START, 8'h00, 16'h0000, 4'h0);
    // A zero burst is rejected; then the extreme priorities and bursts, with a tie at
    // the head and a tie at the tail of the ring so that ties land behind earlier jobs.
    issue(rrss_pkg::FUNC_LOAD, 8'hFF, 16'h0000, 4'h0);
    issue(rrss_pkg::FUNC_LOAD, 8'h00, 16'hFFFF, 4'hF);
    issue(rrss_pkg::FUNC_LOAD, 8'hFF, 16'd1, 4'h0);
    issue(rrss_pkg::FUNC_LOAD, 8'h00, 16'd1, 4'h0);
    issue(rrss_pkg::FUNC_LOAD, 8'hFF, 16'd3, 4'h0);
    // Job 15 has not been loaded yet.
    issue(rrss_pkg::FUNC_START, 8'h00, 16'h0000, 4'hF);

    // Fill the table with random jobs. About half the priorities come from four values
    // only, so that ties are common; one job gets a burst with the top bit set so that
    // the long tail of the run is shared by two large jobs.
    jobs = 4;
    while (jobs < 16) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        issue(FUNC_UNUSED, 8'($urandom), 16'($urandom), 4'($urandom));
      end else if (pick < 10) begin
        issue(rrss_pkg::FUNC_SLICE, 8'($urandom), 16'($urandom), 4'($urandom));
      end else if (pick < 15) begin
        issue(rrss_pkg::FUNC_LOAD, 8'($urandom), 16'h0000, 4'($urandom));
      end else if (pick < 20) begin
        issue(rrss_pkg::FUNC_START, 8'($urandom), 16'($urandom),
              4'($urandom_range(jobs, 15)));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          pri = 8'($urandom_range(0, 3) * 85);
        end else begin
          pri = 8'($urandom);
        end
        if (jobs == 4) begin
          burst = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        end else if ($urandom_range(0, 4) == 0) begin
          burst = 16'($urandom_range(401, 4000));
        end else begin
          burst = 16'($urandom_range(1, 400));
        end
        issue(rrss_pkg::FUNC_LOAD, pri, burst, 4'($urandom));
        jobs++;
      end
    end

    // The table is full now, so a further load is rejected. Then one start from a
    // random job, a second start that must be refused, and a load after start.
    issue(rrss_pkg::FUNC_LOAD, 8'h80, 16'd5, 4'h0);
    issue(rrss_pkg::FUNC_START, 8'($urandom), 16'($urandom), 4'($urandom));
    issue(rrss_pkg::FUNC_START, 8'($urandom), 16'($urandom), 4'($urandom));
    issue(rrss_pkg::FUNC_LOAD, 8'h10, 16'h7FFF, 4'h0);

    // Slicing at the quantum left by reset; short jobs are clipped to what remains.
    run_slices(150);

    // The smallest quantum, sent back to back with no idle cycles.
    write_quantum(8'd1);
    steady = 1'b1;
    run_slices(150);
    steady = 1'b0;

    // A few random quanta in between.
    repeat (3) begin
      write_quantum(8'($urandom_range(3, 254)));
      run_slices(100);
    end

    // The largest quantum, until the scheduler reports that all work is over.
    write_quantum(8'hFF);
    count = 0;
    while (!work_over && count < 2000) begin
      run_slices(1);
      count++;
    end

    // Once the ring is empty every slice reports that no work is left.
    write_quantum(8'($urandom_range(1, 255)));
    run_slices(300);

    // Wait for the last beats, then give the block time to show any stray beat.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
